### src/sacta_pkg.sv
package sacta_pkg;

	// Field widths of the request and result words
	localparam int ADDR_W  = 48;
	localparam int FUNC_W  = 2;
	localparam int STATE_W = 3;
	localparam int LOB_W   = 4;
	localparam int DATA_W  = 56;

	// Line offset register after reset
	localparam logic [LOB_W-1:0] LOB_RESET = 4'd6;

	// Default geometry
	localparam int WAYS_DEF      = 4;
	localparam int SETS_LOG2_DEF = 6;
	localparam int AGE_BITS_DEF  = 8;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FILL   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_INVAL  = 2'd3;

	// Line states
	localparam logic [STATE_W-1:0] ST_INVALID = 3'd0;
	localparam logic [STATE_W-1:0] ST_FILLING = 3'd4;

endpackage

### src/set_assoc_cache_tag_array_top.sv
// A word is accepted, then the ways of its set are scanned one per cycle through a single
// compare unit, until a hit, a free way for a fill or the last way; then the result register
// is loaded once the output is free. s_tready stays low meanwhile, so one word is in flight.
// Reset: arst_n clears control state; then a clearing pass resets the line states and ages
// of all WAYS * 2^SETS_LOG2 lines (256 by default), with s_tready low until it ends.
module set_assoc_cache_tag_array_top #(
	parameter int WAYS      = sacta_pkg::WAYS_DEF,
	parameter int SETS_LOG2 = sacta_pkg::SETS_LOG2_DEF,
	parameter int AGE_BITS  = sacta_pkg::AGE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: line_offset_bits
	input  logic                          cfg_we,
	input  logic [sacta_pkg::LOB_W-1:0]   cfg_wdata,
	// request: func[1:0], addr[49:2], new_state[52:50], zero[55:53]
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sacta_pkg::DATA_W-1:0]  s_tdata,
	// result: hit[0], line_state[3:1], victim_valid[4], victim_addr[52:5], zero[55:53]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sacta_pkg::DATA_W-1:0]  m_tdata
);
	import sacta_pkg::*;

	localparam int NSETS  = 1 << SETS_LOG2;
	localparam int NLINES = WAYS * NSETS;
	localparam int IDX_W  = (NLINES > 1) ? $clog2(NLINES) : 1;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SET_W  = (SETS_LOG2 > 0) ? SETS_LOG2 : 1;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	// Control state
	logic [1:0]          state_q;
	logic [IDX_W-1:0]    clr_q;
	logic [WAY_W-1:0]    way_q;
	logic [LOB_W-1:0]    lob_q;
	logic                out_valid_q;

	// Request held during the scan
	logic [FUNC_W-1:0]   func_q;
	logic [ADDR_W-1:0]   line_q;
	logic [STATE_W-1:0]  nst_q;
	logic [SET_W-1:0]    set_q;

	// Victim search state
	logic [AGE_BITS-1:0] max_age_q;
	logic [WAY_W-1:0]    vic_q;
	logic [ADDR_W-1:0]   vic_addr_q;

	// Finished result and output register
	logic                res_hit_q;
	logic [STATE_W-1:0]  res_st_q;
	logic                res_vv_q;
	logic [ADDR_W-1:0]   res_va_q;
	logic [DATA_W-1:0]   out_data_q;

	// Memories and their registered read data
	logic [ADDR_W-1:0]   addr_mem [NLINES];
	logic [STATE_W-1:0]  st_mem   [NLINES];
	logic [AGE_BITS-1:0] age_mem  [NLINES];
	logic [ADDR_W-1:0]   addr_rd_q;
	logic [STATE_W-1:0]  st_rd_q;
	logic [AGE_BITS-1:0] age_rd_q;

	logic                accept;
	logic [FUNC_W-1:0]   in_func;
	logic [ADDR_W-1:0]   in_addr;
	logic [STATE_W-1:0]  in_nst;
	logic [ADDR_W-1:0]   in_shift;
	logic [SET_W-1:0]    in_set;
	logic [ADDR_W-1:0]   in_line;

	logic [WAY_W-1:0]    rd_way;
	logic [SET_W-1:0]    rd_set;
	logic [IDX_W-1:0]    rd_idx;
	logic [IDX_W-1:0]    cur_idx;
	logic [WAY_W-1:0]    wr_way;
	logic [IDX_W-1:0]    wr_idx;
	logic                last_way;

	logic                cur_valid;
	logic                match;
	logic [AGE_BITS-1:0] age_inc;
	logic                older;

	logic                fill_done;
	logic [WAY_W-1:0]    fill_vic;
	logic                fill_vv;
	logic [ADDR_W-1:0]   fill_va;
	logic                scan_done;

	logic                st_we;
	logic [IDX_W-1:0]    st_wa;
	logic [STATE_W-1:0]  st_wd;
	logic                age_we;
	logic [IDX_W-1:0]    age_wa;
	logic [AGE_BITS-1:0] age_wd;
	logic                addr_we;

	// Unpack the request word
	assign in_func = s_tdata[FUNC_W-1:0];
	assign in_addr = s_tdata[FUNC_W +: ADDR_W];
	assign in_nst  = s_tdata[FUNC_W+ADDR_W +: STATE_W];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Truncate the address to its line and pick the set
	assign in_shift = in_addr >> lob_q;
	assign in_set   = (SETS_LOG2 == 0) ? '0 : in_shift[SET_W-1:0];
	assign in_line  = in_addr & ~((ADDR_W'(1) << lob_q) - ADDR_W'(1));

	// Read address: way 0 on accept, then the next way of the set
	assign last_way = (way_q == WAY_W'(WAYS - 1));
	assign rd_way   = (state_q == S_IDLE) ? '0 : (last_way ? way_q : way_q + WAY_W'(1));
	assign rd_set   = (state_q == S_IDLE) ? in_set : set_q;
	assign rd_idx   = IDX_W'(rd_set) * IDX_W'(WAYS) + IDX_W'(rd_way);
	assign cur_idx  = IDX_W'(set_q) * IDX_W'(WAYS) + IDX_W'(way_q);

	// Shared compare unit on the way just read
	assign cur_valid = (st_rd_q != ST_INVALID);
	assign match     = cur_valid && (addr_rd_q == line_q);
	assign age_inc   = (age_rd_q == '1) ? age_rd_q : age_rd_q + AGE_BITS'(1);
	assign older     = (age_rd_q > max_age_q);

	// Victim choice for a fill
	always_comb begin
		fill_done = 1'b0;
		fill_vic  = way_q;
		fill_vv   = 1'b0;
		fill_va   = '0;
		if (!cur_valid) begin
			fill_done = 1'b1;
		end else if (last_way) begin
			fill_done = 1'b1;
			fill_vv   = 1'b1;
			if (way_q == '0 || older) begin
				fill_va = addr_rd_q;
			end else begin
				fill_vic = vic_q;
				fill_va  = vic_addr_q;
			end
		end
	end

	assign scan_done = (func_q == FUNC_FILL) ? fill_done : (match || last_way);

	// Write port control
	assign wr_way = (func_q == FUNC_FILL) ? fill_vic : way_q;
	assign wr_idx = IDX_W'(set_q) * IDX_W'(WAYS) + IDX_W'(wr_way);

	always_comb begin
		st_we   = 1'b0;
		st_wa   = wr_idx;
		st_wd   = ST_FILLING;
		age_we  = 1'b0;
		age_wa  = cur_idx;
		age_wd  = age_inc;
		addr_we = 1'b0;
		if (state_q == S_CLEAR) begin
			st_we  = 1'b1;
			st_wa  = clr_q;
			st_wd  = ST_INVALID;
			age_we = 1'b1;
			age_wa = clr_q;
			age_wd = '0;
		end else if (state_q == S_SCAN) begin
			if (func_q == FUNC_FILL) begin
				st_we   = fill_done;
				addr_we = fill_done;
			end else if (match) begin
				if (func_q == FUNC_SET && nst_q <= ST_FILLING) begin
					st_we = 1'b1;
					st_wd = nst_q;
				end else if (func_q == FUNC_INVAL) begin
					st_we = 1'b1;
					st_wd = ST_INVALID;
				end
			end else begin
				age_we = 1'b1;
			end
		end
	end

	// Line address memory
	always_ff @(posedge clk) begin
		if (addr_we) begin
			addr_mem[wr_idx] <= line_q;
		end
		addr_rd_q <= addr_mem[rd_idx];
	end

	// Line state memory
	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_wa] <= st_wd;
		end
		st_rd_q <= st_mem[rd_idx];
	end

	// Age memory
	always_ff @(posedge clk) begin
		if (age_we) begin
			age_mem[age_wa] <= age_wd;
		end
		age_rd_q <= age_mem[rd_idx];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			way_q       <= '0;
			lob_q       <= LOB_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				lob_q <= cfg_wdata;
			end
			// drop the result once taken, unless a new one is loaded now
			if (out_valid_q && m_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(NLINES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					way_q <= '0;
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= S_DONE;
					end else begin
						way_q <= way_q + WAY_W'(1);
					end
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request, victim search and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= in_func;
			line_q <= in_line;
			nst_q  <= in_nst;
			set_q  <= in_set;
		end
		if (state_q == S_SCAN) begin
			// track the oldest way seen so far
			if (way_q == '0 || older) begin
				max_age_q  <= age_rd_q;
				vic_q      <= way_q;
				vic_addr_q <= addr_rd_q;
			end
			if (scan_done) begin
				if (func_q == FUNC_FILL) begin
					res_hit_q <= 1'b0;
					res_st_q  <= ST_INVALID;
					res_vv_q  <= fill_vv;
					res_va_q  <= fill_va;
				end else begin
					res_hit_q <= match;
					res_st_q  <= match ? st_rd_q : ST_INVALID;
					res_vv_q  <= 1'b0;
					res_va_q  <= '0;
				end
			end
		end
		if (state_q == S_DONE && (!out_valid_q || m_tready)) begin
			out_data_q <= {{(DATA_W - ADDR_W - STATE_W - 2){1'b0}},
				res_va_q, res_vv_q, res_st_q, res_hit_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### sim/tb.sv
module tb;
	import sacta_pkg::*;

	localparam int WAYS      = WAYS_DEF;
	localparam int SETS_LOG2 = SETS_LOG2_DEF;
	localparam int AGE_BITS  = AGE_BITS_DEF;
	localparam int NSETS     = 1 << SETS_LOG2;
	localparam int NLINES    = NSETS * WAYS;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 70;

	// Line states with no name in the package, and a code that set state must ignore
	localparam logic [STATE_W-1:0] ST_SHARED      = 3'd1;
	localparam logic [STATE_W-1:0] ST_EXCLUSIVE   = 3'd2;
	localparam logic [STATE_W-1:0] ST_MODIFIED    = 3'd3;
	localparam logic [STATE_W-1:0] ST_UNUSED_CODE = 3'd7;

	// Result word layout, lowest field last
	typedef struct packed {
		bit [ADDR_W-1:0]  victim_addr;
		bit               victim_valid;
		bit [STATE_W-1:0] line_state;
		bit               hit;
	} tag_result_t;

	// Shadow copy of the tag array and the queue of results it predicts
	class tag_scoreboard;
		bit [ADDR_W-1:0]   line_tag [NLINES];
		bit [STATE_W-1:0]  line_st  [NLINES];
		bit [AGE_BITS-1:0] line_age [NLINES];
		bit [LOB_W-1:0]    offset_bits;
		tag_result_t       expected_q [$];
		int                errors;

		function new();
			for (int i = 0; i < NLINES; i++) begin
				line_tag[i] = '0;
				line_st[i]  = ST_INVALID;
				line_age[i] = '0;
			end
			offset_bits = LOB_RESET;
			errors      = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Apply one accepted request to the shadow array and queue its result
		function void note_request(bit [FUNC_W-1:0] func, bit [ADDR_W-1:0] addr,
				bit [STATE_W-1:0] nst);
			bit [ADDR_W-1:0]   low_mask;
			bit [ADDR_W-1:0]   line_addr;
			bit [AGE_BITS-1:0] oldest;
			int                base;
			int                vic;
			int                e;
			bit                done;
			tag_result_t       res;
			low_mask  = (48'd1 << offset_bits) - 48'd1;
			line_addr = addr & ~low_mask;
			base      = int'((addr >> offset_bits) & (NSETS - 1)) * WAYS;
			res       = '0;
			done      = 1'b0;
			if (func == FUNC_FILL) begin
				// pick the victim: invalid way 0, first invalid way, else oldest
				vic = 0;
				if (line_st[base] != ST_INVALID) begin
					oldest = line_age[base];
					for (int w = 1; w < WAYS; w++) begin
						if (!done) begin
							if (line_st[base + w] == ST_INVALID) begin
								vic  = w;
								done = 1'b1;
							end else if (line_age[base + w] > oldest) begin
								oldest = line_age[base + w];
								vic    = w;
							end
						end
					end
				end
				e = base + vic;
				if (line_st[e] != ST_INVALID) begin
					res.victim_valid = 1'b1;
					res.victim_addr  = line_tag[e];
				end
				line_st[e]  = ST_FILLING;
				line_tag[e] = line_addr;
			end else begin
				// scan from way 0, aging every way passed without a match
				for (int w = 0; w < WAYS; w++) begin
					e = base + w;
					if (!done) begin
						if (line_st[e] != ST_INVALID && line_tag[e] == line_addr) begin
							done           = 1'b1;
							res.hit        = 1'b1;
							res.line_state = line_st[e];
							if (func == FUNC_SET) begin
								if (nst <= ST_FILLING)
									line_st[e] = nst;
							end else if (func == FUNC_INVAL) begin
								line_st[e] = ST_INVALID;
							end
						end else if (line_age[e] != '1) begin
							line_age[e]++;
						end
					end
				end
			end
			expected_q.insert(expected_q.size(), res);
		endfunction

		function void compare(string name, bit [ADDR_W-1:0] want, bit [ADDR_W-1:0] got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			end
		endfunction

		// Match one result word against the oldest prediction
		function void check_result(bit [DATA_W-1:0] data);
			tag_result_t got;
			tag_result_t want;
			got = data[$bits(tag_result_t)-1:0];
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result word %h, expected none", $time, data);
				return;
			end
			want = expected_q.pop_front();
			compare("hit", ADDR_W'(want.hit), ADDR_W'(got.hit));
			compare("line_state", ADDR_W'(want.line_state), ADDR_W'(got.line_state));
			compare("victim_valid", ADDR_W'(want.victim_valid), ADDR_W'(got.victim_valid));
			compare("victim_addr", want.victim_addr, got.victim_addr);
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [LOB_W-1:0]  cfg_wdata = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	// request: func[1:0], addr[49:2], new_state[52:50], zero[55:53]
	logic [DATA_W-1:0] s_tdata   = '0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	// result: hit[0], line_state[3:1], victim_valid[4], victim_addr[52:5], zero[55:53]
	logic [DATA_W-1:0] m_tdata;

	tag_scoreboard     board;
	bit [ADDR_W-1:0]   line_pool [$];
	int                send_idle_pct = 0;
	int                stall_pct     = 0;
	int                hold_left     = 0;
	int                quiet_cycles  = 0;
	bit                hot_only      = 1'b0;

	set_assoc_cache_tag_array_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Take result words, stalling at random or for a requested hold-off
	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready === 1'b1)
			board.check_result(m_tdata);
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// End the run when no word moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one request word, idling first at random, and hold it until taken
	task automatic send_req(bit [FUNC_W-1:0] func, bit [ADDR_W-1:0] addr,
			bit [STATE_W-1:0] nst);
		bit [ADDR_W-1:0] low_mask;
		low_mask = (48'd1 << board.offset_bits) - 48'd1;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, nst, addr, func};
		do @(posedge clk); while (s_tready !== 1'b1);
		board.note_request(func, addr, nst);
		if (func == FUNC_FILL) begin
			line_pool.insert(line_pool.size(), addr & ~low_mask);
			if (line_pool.size() > 24)
				void'(line_pool.pop_front());
		end
	endtask

	// Build a random request: mostly lines already filled or two crowded sets
	task automatic send_random();
		bit [63:0]        raw;
		bit [ADDR_W-1:0]  low_mask;
		bit [ADDR_W-1:0]  tag_part;
		bit [ADDR_W-1:0]  set_part;
		bit [ADDR_W-1:0]  addr;
		bit [FUNC_W-1:0]  func;
		bit [STATE_W-1:0] nst;
		int               r_func;
		int               r_addr;
		raw      = {$urandom, $urandom};
		low_mask = (48'd1 << board.offset_bits) - 48'd1;
		r_func   = $urandom_range(0, 99);
		r_addr   = hot_only ? 60 : $urandom_range(0, 99);
		nst      = STATE_W'($urandom_range(0, 7));
		tag_part = ADDR_W'($urandom_range(0, 5));
		set_part = ($urandom_range(0, 3) == 0) ? ADDR_W'(1) : ADDR_W'(0);
		if (r_func < 30)
			func = FUNC_FILL;
		else if (r_func < 60)
			func = FUNC_LOOKUP;
		else if (r_func < 85)
			func = FUNC_SET;
		else
			func = FUNC_INVAL;
		if (line_pool.size() != 0 && r_addr < 50)
			addr = line_pool[$urandom_range(0, line_pool.size() - 1)] | (raw[47:0] & low_mask);
		else if (r_addr < 85)
			addr = (tag_part << (board.offset_bits + SETS_LOG2))
				| (set_part << board.offset_bits) | (raw[47:0] & low_mask);
		else
			addr = raw[47:0];
		send_req(func, addr, nst);
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (WAYS + 2) @(posedge clk);
	endtask

	task automatic write_offset_bits(bit [LOB_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		board.offset_bits = value;
		line_pool.delete();
	endtask

	// Walk set 0 through empty, partial and full states at 64-byte lines, with one fill in set 63
	task automatic directed();
		send_req(FUNC_LOOKUP, 48'h0, ST_INVALID);
		send_req(FUNC_FILL,   48'h10, ST_INVALID);
		send_req(FUNC_LOOKUP, 48'h3F, ST_INVALID);
		send_req(FUNC_SET,    48'h0, ST_MODIFIED);
		send_req(FUNC_SET,    48'h0, ST_UNUSED_CODE);
		send_req(FUNC_LOOKUP, 48'h0, ST_INVALID);
		send_req(FUNC_FILL,   48'hFFFF_FFFF_FFFF, ST_INVALID);
		send_req(FUNC_LOOKUP, 48'hFFFF_FFFF_FFC0, ST_UNUSED_CODE);
		send_req(FUNC_FILL,   48'h1000, ST_INVALID);
		send_req(FUNC_FILL,   48'h2000, ST_INVALID);
		send_req(FUNC_FILL,   48'h3000, ST_INVALID);
		send_req(FUNC_LOOKUP, 48'h3000, ST_INVALID);
		send_req(FUNC_FILL,   48'h4000, ST_INVALID);
		send_req(FUNC_INVAL,  48'h1000, ST_INVALID);
		send_req(FUNC_INVAL,  48'h1000, ST_INVALID);
		send_req(FUNC_SET,    48'h2000, ST_INVALID);
		send_req(FUNC_FILL,   48'h5000, ST_INVALID);
		send_req(FUNC_LOOKUP, 48'h9000, ST_INVALID);
		send_req(FUNC_SET,    48'h3000, ST_FILLING);
		send_req(FUNC_SET,    48'h3000, ST_SHARED);
		send_req(FUNC_SET,    48'h3000, ST_EXCLUSIVE);
		send_req(FUNC_INVAL,  48'h9000, ST_INVALID);
		send_req(FUNC_FILL,   48'h3000, ST_INVALID);
		send_req(FUNC_LOOKUP, 48'h3000, ST_INVALID);
	endtask

	initial begin
		bit [LOB_W-1:0] phase_lob [PHASES];
		board = new();
		phase_lob = '{4'd2, 4'd12, 4'd0, 4'd15, 4'd6, 4'd9, 4'd3, 4'd11};
		phase_lob[PHASES-1] = LOB_W'($urandom_range(0, 15));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_offset_bits(LOB_RESET);
		directed();
		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_offset_bits(phase_lob[p]);
			send_idle_pct = (p % 4 == 1) ? 65 : (p % 4 == 3) ? 17 : 0;
			stall_pct     = (p % 4 == 2) ? 65 : (p % 4 == 3) ? 17 : 0;
			hot_only      = (p == 5);
			// hold the result side off while requests keep coming, to back up the input
			if (p == 4)
				hold_left = 300;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// pause the request side mid-phase until all results are back
				if (p == 6 && i == PHASE_ITEMS / 2)
					drain();
				send_random();
			end
		end
		drain();
		repeat (2 * WAYS) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
